@@ src/hsv2rgb_pkg.sv @@
// Shared types and constants for the HSV to RGB converter.
// Used by every module of the block; depends on nothing.
package hsv2rgb_pkg;

  // Pipeline depth: one load enable and one valid bit per stage.
  localparam int NUM_STAGES = 7;

  // Fixed field widths.
  localparam int IN_W  = 16;
  localparam int PCT_W = 7;
  localparam int HUE_W = 9;
  localparam int CH_W  = 8;

  // Scaling constants.
  localparam logic [PCT_W-1:0] PCT_MAX  = 7'd100;
  localparam logic [HUE_W-1:0] HUE_FULL = 9'd360;
  localparam logic [HUE_W-1:0] HUE_60   = 9'd60;
  localparam logic [HUE_W-1:0] HUE_120  = 9'd120;
  localparam logic [HUE_W-1:0] HUE_180  = 9'd180;
  localparam logic [HUE_W-1:0] HUE_240  = 9'd240;
  localparam logic [HUE_W-1:0] HUE_300  = 9'd300;

  // Reciprocals for exact truncating division by constants.
  // x / 360 for x up to 32768: (x * 46604) >> 24.
  localparam logic [15:0] HUE_RECIP   = 16'd46604;
  // x / 100 for x up to 25500: (x * 20972) >> 21.
  localparam logic [14:0] PCT_RECIP   = 15'd20972;
  // x / 10000 for x up to 2550000: (x * 1717987) >> 34.
  localparam logic [20:0] LO_RECIP    = 21'd1717987;
  // x / 60 for x up to 15300: (x * 17477) >> 20.
  localparam logic [14:0] SIXTY_RECIP = 15'd17477;

  // Hue sector: which channel is strongest and which one is interpolated.
  typedef enum logic [2:0] {
    SEC_R_G = 3'd0,  // red max, green rising, blue min
    SEC_G_R = 3'd1,  // green max, red falling, blue min
    SEC_G_B = 3'd2,  // green max, blue rising, red min
    SEC_B_G = 3'd3,  // blue max, green falling, red min
    SEC_B_R = 3'd4,  // blue max, red rising, green min
    SEC_R_B = 3'd5   // red max, blue falling, green min
  } sector_t;

  // Input word.
  typedef struct packed {
    logic signed [IN_W-1:0] hue_degrees;
    logic signed [IN_W-1:0] saturation_pct;
    logic signed [IN_W-1:0] value_pct;
  } hsv_t;

  // Output word.
  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  // Per-stage load enables from the pipeline control.
  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
  } pipe_en_t;

endpackage

@@ src/hsv_to_rgb_integer.sv @@
// HSV to RGB converter: one input word per clock while the output side takes
// every word, and seven register stages from an accepted word to its result on
// the output register. The stages follow the chain of reciprocal
// multiplications (hue by 360, levels by 100 and 10000, interpolation by 60),
// each followed by a register. A stall holds the full pipeline in place, while
// empty stages still fill, so words keep entering until every stage holds one.
// Results come out in input order, one per input.
// Depends on hsv2rgb_pkg and the ctrl, front, level and blend modules.
module hsv_to_rgb_integer
  import hsv2rgb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic hsv_valid,
  output logic hsv_ready,
  input  hsv_t hsv,
  output logic rgb_valid,
  input  logic rgb_ready,
  output rgb_t rgb
);

  pipe_en_t         en;
  logic [HUE_W-1:0] hue;
  logic [14:0]      val_scaled;
  logic [PCT_W-1:0] sat_inv;
  logic [CH_W-1:0]  hi;
  logic [CH_W-1:0]  lo;
  sector_t          sector;
  logic [5:0]       frac;

  // Handshake and stage enables.
  hsv2rgb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .hsv_valid (hsv_valid),
    .hsv_ready (hsv_ready),
    .rgb_valid (rgb_valid),
    .rgb_ready (rgb_ready),
    .en        (en)
  );

  // Clamp and hue wrap.
  hsv2rgb_front u_front (
    .clk        (clk),
    .en         (en),
    .hsv        (hsv),
    .hue        (hue),
    .val_scaled (val_scaled),
    .sat_inv    (sat_inv)
  );

  // Channel levels and sector.
  hsv2rgb_level u_level (
    .clk        (clk),
    .en         (en),
    .hue        (hue),
    .val_scaled (val_scaled),
    .sat_inv    (sat_inv),
    .hi         (hi),
    .lo         (lo),
    .sector     (sector),
    .frac       (frac)
  );

  // Interpolation and output word.
  hsv2rgb_blend u_blend (
    .clk    (clk),
    .en     (en),
    .hi     (hi),
    .lo     (lo),
    .sector (sector),
    .frac   (frac),
    .rgb    (rgb)
  );

endmodule

@@ src/hsv2rgb_ctrl.sv @@
// Pipeline control for the HSV to RGB converter: valid bits and stage loads.
// Depends on hsv2rgb_pkg.
module hsv2rgb_ctrl
  import hsv2rgb_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     hsv_valid,
  output logic     hsv_ready,
  output logic     rgb_valid,
  input  logic     rgb_ready,
  output pipe_en_t en
);

  logic [NUM_STAGES-1:0] valid;

  // A stage loads when it is empty or when its contents move on.
  always_comb begin
    en.load[NUM_STAGES-1] = !valid[NUM_STAGES-1] || rgb_ready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      en.load[i] = !valid[i] || en.load[i+1];
    end
  end

  assign hsv_ready = en.load[0];
  assign rgb_valid = valid[NUM_STAGES-1];

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en.load[0]) begin
        valid[0] <= hsv_valid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (en.load[i]) begin
          valid[i] <= valid[i-1];
        end
      end
    end
  end

endmodule

@@ src/hsv2rgb_front.sv @@
// Front stages: clamp saturation and value, wrap the hue into 0..359.
// Depends on hsv2rgb_pkg; stages 1 and 2 of the pipeline.
module hsv2rgb_front
  import hsv2rgb_pkg::*;
(
  input  logic             clk,
  input  pipe_en_t         en,
  input  hsv_t             hsv,
  output logic [HUE_W-1:0] hue,
  output logic [14:0]      val_scaled,
  output logic [PCT_W-1:0] sat_inv
);

  logic            neg_in;
  logic [15:0]     mag_in;
  logic [31:0]     quot_prod;
  logic [PCT_W-1:0] sat_in;
  logic [PCT_W-1:0] val_in;

  logic             s1_neg;
  logic [15:0]      s1_mag;
  logic [6:0]       s1_quot;
  logic [PCT_W-1:0] s1_sat;
  logic [PCT_W-1:0] s1_val;

  logic [15:0]      rem_full;
  logic [HUE_W-1:0] rem;
  logic [HUE_W-1:0] hue_next;

  // Magnitude of the hue and its quotient by 360 through the reciprocal.
  always_comb begin
    neg_in    = hsv.hue_degrees[IN_W-1];
    mag_in    = neg_in ? 16'(-hsv.hue_degrees) : 16'(hsv.hue_degrees);
    quot_prod = mag_in * HUE_RECIP;
  end

  // Clamp both percentages into 0..100.
  always_comb begin
    if (hsv.saturation_pct[IN_W-1]) begin
      sat_in = '0;
    end else if (hsv.saturation_pct > IN_W'(PCT_MAX)) begin
      sat_in = PCT_MAX;
    end else begin
      sat_in = hsv.saturation_pct[PCT_W-1:0];
    end
    if (hsv.value_pct[IN_W-1]) begin
      val_in = '0;
    end else if (hsv.value_pct > IN_W'(PCT_MAX)) begin
      val_in = PCT_MAX;
    end else begin
      val_in = hsv.value_pct[PCT_W-1:0];
    end
  end

  // Stage 1.
  always_ff @(posedge clk) begin
    if (en.load[0]) begin
      s1_neg  <= neg_in;
      s1_mag  <= mag_in;
      s1_quot <= quot_prod[30:24];
      s1_sat  <= sat_in;
      s1_val  <= val_in;
    end
  end

  // Remainder of the magnitude; a negative hue folds back from 360.
  always_comb begin
    rem_full = s1_mag - 16'(s1_quot) * 16'(HUE_FULL);
    rem      = rem_full[HUE_W-1:0];
    if (s1_neg && (rem != '0)) begin
      hue_next = HUE_FULL - rem;
    end else begin
      hue_next = rem;
    end
  end

  // Stage 2: wrapped hue, 255 * value and 100 - saturation.
  always_ff @(posedge clk) begin
    if (en.load[1]) begin
      hue        <= hue_next;
      val_scaled <= {s1_val, 8'b0} - 15'(s1_val);
      sat_inv    <= PCT_MAX - s1_sat;
    end
  end

endmodule

@@ src/hsv2rgb_level.sv @@
// Level stages: strongest and weakest channel levels, hue sector and offset.
// Depends on hsv2rgb_pkg; stages 3 and 4 of the pipeline.
module hsv2rgb_level
  import hsv2rgb_pkg::*;
(
  input  logic             clk,
  input  pipe_en_t         en,
  input  logic [HUE_W-1:0] hue,
  input  logic [14:0]      val_scaled,
  input  logic [PCT_W-1:0] sat_inv,
  output logic [CH_W-1:0]  hi,
  output logic [CH_W-1:0]  lo,
  output sector_t          sector,
  output logic [5:0]       frac
);

  logic [29:0]      hi_prod;
  logic [21:0]      lo_num_next;

  logic [CH_W-1:0]  s3_hi;
  logic [21:0]      s3_lo_num;
  logic [HUE_W-1:0] s3_hue;

  logic [42:0]      lo_prod;
  sector_t          sector_next;
  logic [HUE_W-1:0] frac_full;

  // 255*v/100 through the reciprocal, and the numerator 255*v*(100-s).
  always_comb begin
    hi_prod     = val_scaled * PCT_RECIP;
    lo_num_next = val_scaled * sat_inv;
  end

  // Stage 3.
  always_ff @(posedge clk) begin
    if (en.load[2]) begin
      s3_hi     <= hi_prod[28:21];
      s3_lo_num <= lo_num_next;
      s3_hue    <= hue;
    end
  end

  // Numerator divided by 10000 through the reciprocal.
  always_comb begin
    lo_prod = s3_lo_num * LO_RECIP;
  end

  // Sector select; a boundary hue belongs to the lower sector.
  always_comb begin
    if (s3_hue <= HUE_60) begin
      sector_next = SEC_R_G;
      frac_full   = s3_hue;
    end else if (s3_hue <= HUE_120) begin
      sector_next = SEC_G_R;
      frac_full   = HUE_120 - s3_hue;
    end else if (s3_hue <= HUE_180) begin
      sector_next = SEC_G_B;
      frac_full   = s3_hue - HUE_120;
    end else if (s3_hue <= HUE_240) begin
      sector_next = SEC_B_G;
      frac_full   = HUE_240 - s3_hue;
    end else if (s3_hue <= HUE_300) begin
      sector_next = SEC_B_R;
      frac_full   = s3_hue - HUE_240;
    end else begin
      sector_next = SEC_R_B;
      frac_full   = HUE_FULL - s3_hue;
    end
  end

  // Stage 4.
  always_ff @(posedge clk) begin
    if (en.load[3]) begin
      hi     <= s3_hi;
      lo     <= lo_prod[41:34];
      sector <= sector_next;
      frac   <= frac_full[5:0];
    end
  end

endmodule

@@ src/hsv2rgb_blend.sv @@
// Blend stages: interpolate the middle channel and route the three channels.
// Depends on hsv2rgb_pkg; stages 5 to 7 of the pipeline, the last one is the output.
module hsv2rgb_blend
  import hsv2rgb_pkg::*;
(
  input  logic            clk,
  input  pipe_en_t        en,
  input  logic [CH_W-1:0] hi,
  input  logic [CH_W-1:0] lo,
  input  sector_t         sector,
  input  logic [5:0]      frac,
  output rgb_t            rgb
);

  logic [13:0]     ip_next;

  logic [13:0]     s5_ip;
  logic [CH_W-1:0] s5_hi;
  logic [CH_W-1:0] s5_lo;
  sector_t         s5_sector;

  logic [28:0]     off_prod;

  logic [CH_W-1:0] s6_off;
  logic [CH_W-1:0] s6_hi;
  logic [CH_W-1:0] s6_lo;
  sector_t         s6_sector;

  logic [CH_W-1:0] mid;
  rgb_t            rgb_next;

  // Span between the extremes scaled by the hue offset.
  always_comb begin
    ip_next = 14'(hi - lo) * 14'(frac);
  end

  // Stage 5.
  always_ff @(posedge clk) begin
    if (en.load[4]) begin
      s5_ip     <= ip_next;
      s5_hi     <= hi;
      s5_lo     <= lo;
      s5_sector <= sector;
    end
  end

  // Divide by 60 through the reciprocal.
  always_comb begin
    off_prod = s5_ip * SIXTY_RECIP;
  end

  // Stage 6.
  always_ff @(posedge clk) begin
    if (en.load[5]) begin
      s6_off    <= off_prod[27:20];
      s6_hi     <= s5_hi;
      s6_lo     <= s5_lo;
      s6_sector <= s5_sector;
    end
  end

  // Middle channel, then route the levels by sector.
  always_comb begin
    mid = s6_off + s6_lo;
    case (s6_sector)
      SEC_R_G: begin
        rgb_next = '{red: s6_hi, green: mid, blue: s6_lo};
      end
      SEC_G_R: begin
        rgb_next = '{red: mid, green: s6_hi, blue: s6_lo};
      end
      SEC_G_B: begin
        rgb_next = '{red: s6_lo, green: s6_hi, blue: mid};
      end
      SEC_B_G: begin
        rgb_next = '{red: s6_lo, green: mid, blue: s6_hi};
      end
      SEC_B_R: begin
        rgb_next = '{red: mid, green: s6_lo, blue: s6_hi};
      end
      SEC_R_B: begin
        rgb_next = '{red: s6_hi, green: s6_lo, blue: mid};
      end
      default: begin
        rgb_next = '0;
      end
    endcase
  end

  // Stage 7: output register.
  always_ff @(posedge clk) begin
    if (en.load[6]) begin
      rgb <= rgb_next;
    end
  end

endmodule
